[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When cond holds at a clock edge, prop must hold at the same edge
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`endif

[rtl/hslp_pkg.sv]
`default_nettype none

package hslp_pkg;

  // table geometry (SLOTS is a power of two)
  localparam int SLOTS      = 256;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int KEY_BITS   = 32;
  localparam int COUNT_BITS = SLOT_BITS + 1;

  // multiplicative hash constant, split in halves
  localparam logic [31:0] HASH_MUL_HI = 32'h9E37_79B9;
  localparam logic [31:0] HASH_MUL_LO = 32'h7F4A_7C15;

  typedef logic [1:0] slot_status_t;

  localparam slot_status_t ST_FREE = 2'd0;
  localparam slot_status_t ST_USED = 2'd1;
  localparam slot_status_t ST_DEAD = 2'd2;

  // request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  typedef struct packed {
    slot_status_t          status;
    logic [KEY_BITS-1:0]   key;
  } slot_entry_t;

  localparam int ENTRY_BITS = $bits(slot_entry_t);

endpackage

`default_nettype wire

[rtl/hslp_ram.sv]
`default_nettype none

module hslp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 34
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, read-first registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/hslp_hash.sv]
`default_nettype none

module hslp_hash (
  input  wire logic                           clk,
  input  wire logic                           load,
  input  wire logic [hslp_pkg::KEY_BITS-1:0]  key,
  output logic      [hslp_pkg::SLOT_BITS-1:0] start
);

  logic [63:0] prod_lo_r;
  logic [31:0] prod_hi_r;
  logic [63:0] prod_lo_nxt;
  logic [31:0] prod_hi_nxt;
  logic [31:0] hash_top;

  // two 32x32 partial products of the 64-bit hash
  assign prod_lo_nxt = 64'(key) * 64'(hslp_pkg::HASH_MUL_LO);
  assign prod_hi_nxt = 32'(64'(key) * 64'(hslp_pkg::HASH_MUL_HI));

  always_ff @(posedge clk) begin
    if (load) begin
      prod_lo_r <= prod_lo_nxt;
      prod_hi_r <= prod_hi_nxt;
    end
  end

  // upper word of the hash; its top bits pick the start slot
  assign hash_top = prod_lo_r[63:32] + prod_hi_r;
  assign start    = hash_top[31 -: hslp_pkg::SLOT_BITS];

endmodule

`default_nettype wire

[rtl/hash_set_linear_probe_top.sv]
`default_nettype none
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_kind, in_key
// out      output     out_valid / out_stall out_present, out_changed, out_full_res, out_count
//
// Insert, query and delete pass through accept and hash, then probe 1 to SLOTS slots,
// one read per probed slot; the single read port of the slot memory sets the probe rate.
// Clear passes through accept and then SLOTS + 1 sweep steps, one memory read per slot
// with a write back of each used slot as a tombstone.
// After reset a clearing pass frees every slot; no transfer is taken then.
// The result waits in an output register; a stalled output holds the finish of
// the next request, not its acceptance.

`include "assert_macros.svh"

module hash_set_linear_probe_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [hslp_pkg::KEY_BITS-1:0]   in_key,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_present,
  output logic                                 out_changed,
  output logic                                 out_full_res,
  output logic [hslp_pkg::COUNT_BITS-1:0]      out_count
);

  localparam int SB = hslp_pkg::SLOT_BITS;
  localparam int CB = hslp_pkg::COUNT_BITS;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_CLR   = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [SB:0]                    sweep_r, sweep_nxt;
  logic [1:0]                     kind_r;
  logic [hslp_pkg::KEY_BITS-1:0]  key_r;
  logic [SB-1:0]                  idx_r, idx_nxt;
  logic [SB-1:0]                  steps_r, steps_nxt;
  logic                           dead_vld_r, dead_vld_nxt;
  logic [SB-1:0]                  dead_r, dead_nxt;
  logic [CB-1:0]                  count_r, count_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           present_r, present_nxt;
  logic                           changed_r, changed_nxt;
  logic                           full_r, full_nxt;
  logic [CB-1:0]                  out_count_r, out_count_nxt;

  logic                           in_xfer;
  logic                           out_free;
  logic                           out_load;
  logic [SB-1:0]                  start_slot;

  logic                           wr_en;
  logic [SB-1:0]                  wr_addr;
  hslp_pkg::slot_entry_t          wr_data;
  logic [SB-1:0]                  rd_addr;
  hslp_pkg::slot_entry_t          rd_data;

  logic                           is_free, is_match, is_last, probe_done;
  logic                           dead_here, cand_vld;
  logic [SB-1:0]                  cand;
  logic                           ins_ok;
  logic [SB-1:0]                  ins_slot;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  hslp_hash u_hash (
    .clk   (clk),
    .load  (in_xfer),
    .key   (in_key),
    .start (start_slot)
  );

  hslp_ram #(
    .DEPTH (hslp_pkg::SLOTS),
    .WIDTH (hslp_pkg::ENTRY_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // classify the slot just read
  assign is_free    = (rd_data.status == hslp_pkg::ST_FREE);
  assign is_match   = (rd_data.status == hslp_pkg::ST_USED) && (rd_data.key == key_r);
  assign is_last    = (steps_r == SB'(hslp_pkg::SLOTS - 1));
  assign probe_done = is_free || is_match || is_last;
  assign dead_here  = (rd_data.status == hslp_pkg::ST_DEAD) && !dead_vld_r;
  assign cand_vld   = dead_vld_r || dead_here;
  assign cand       = dead_vld_r ? dead_r : idx_r;
  assign ins_ok     = is_free || cand_vld;
  assign ins_slot   = cand_vld ? cand : idx_r;

  // sequencer: init sweep, hash, probe, clear sweep
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    idx_nxt       = idx_r;
    steps_nxt     = steps_r;
    dead_vld_nxt  = dead_vld_r;
    dead_nxt      = dead_r;
    count_nxt     = count_r;
    out_load      = 1'b0;
    present_nxt   = present_r;
    changed_nxt   = changed_r;
    full_nxt      = full_r;
    out_count_nxt = out_count_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '{status: hslp_pkg::ST_FREE, key: key_r};
    rd_addr       = idx_r;

    case (state_r)
      S_INIT: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r[SB-1:0];
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r[SB-1:0] == SB'(hslp_pkg::SLOTS - 1)) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          sweep_nxt = '0;
          state_nxt = (in_kind == hslp_pkg::KIND_CLEAR) ? S_CLR : S_HASH;
        end
      end
      S_HASH: begin
        rd_addr      = start_slot;
        idx_nxt      = start_slot;
        steps_nxt    = '0;
        dead_vld_nxt = 1'b0;
        state_nxt    = S_PROBE;
      end
      S_PROBE: begin
        if (!probe_done) begin
          // advance to the next slot
          idx_nxt   = idx_r + 1'b1;
          steps_nxt = steps_r + 1'b1;
          rd_addr   = idx_r + 1'b1;
          if (dead_here) begin
            dead_vld_nxt = 1'b1;
            dead_nxt     = idx_r;
          end
        end else if (out_free) begin
          out_load    = 1'b1;
          present_nxt = is_match;
          changed_nxt = 1'b0;
          full_nxt    = 1'b0;
          if (kind_r == hslp_pkg::KIND_INSERT && !is_match) begin
            if (ins_ok) begin
              wr_en       = 1'b1;
              wr_addr     = ins_slot;
              wr_data     = '{status: hslp_pkg::ST_USED, key: key_r};
              count_nxt   = count_r + 1'b1;
              changed_nxt = 1'b1;
            end else begin
              full_nxt = 1'b1;
            end
          end else if (kind_r == hslp_pkg::KIND_DELETE && is_match) begin
            wr_en       = 1'b1;
            wr_addr     = idx_r;
            wr_data     = '{status: hslp_pkg::ST_DEAD, key: key_r};
            count_nxt   = (count_r != '0) ? count_r - 1'b1 : count_r;
            changed_nxt = 1'b1;
          end
          out_count_nxt = count_nxt;
          state_nxt     = S_IDLE;
        end
        // otherwise hold: re-read the same slot
      end
      S_CLR: begin
        // read slot sweep (the last slot at the final step), write back slot sweep-1 as tombstone if used
        rd_addr = (sweep_r == CB'(hslp_pkg::SLOTS)) ? SB'(hslp_pkg::SLOTS - 1)
                                                    : sweep_r[SB-1:0];
        wr_addr = SB'(sweep_r - 1'b1);
        wr_data = '{status: hslp_pkg::ST_DEAD, key: rd_data.key};
        wr_en   = (sweep_r != '0) && (rd_data.status == hslp_pkg::ST_USED);
        if (sweep_r != CB'(hslp_pkg::SLOTS)) begin
          sweep_nxt = sweep_r + 1'b1;
        end else if (out_free) begin
          out_load      = 1'b1;
          present_nxt   = 1'b0;
          changed_nxt   = 1'b0;
          full_nxt      = 1'b0;
          count_nxt     = '0;
          out_count_nxt = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: load on finish, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= in_kind;
      key_r  <= in_key;
    end
    idx_r       <= idx_nxt;
    steps_r     <= steps_nxt;
    dead_vld_r  <= dead_vld_nxt;
    dead_r      <= dead_nxt;
    present_r   <= present_nxt;
    changed_r   <= changed_nxt;
    full_r      <= full_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_present  = present_r;
  assign out_changed  = changed_r;
  assign out_full_res = full_r;
  assign out_count    = out_count_r;

  // checks
  `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= CB'(hslp_pkg::SLOTS))
  `ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid_r && full_r,
                out_count_r == CB'(hslp_pkg::SLOTS) && !present_r)
  `ASSERT_IMPLY(a_change_excl, clk, rst_n, out_valid_r && changed_r,
                !full_r && (present_r || out_count_r != '0))
  `ASSERT_IMPLY(a_busy_no_accept, clk, rst_n, in_xfer, !out_load)

endmodule

`default_nettype wire

[verif/tb_hash_set_linear_probe_top.sv]
`timescale 1ns / 1ps

module tb_hash_set_linear_probe_top;

  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int SETTLE_CYCLES = 600;
  localparam int HOLD_AT_ITEM = 350;
  localparam int HOLD_CYCLES  = 400;
  localparam int ITEM_TARGET  = 1500;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [hslp_pkg::KEY_BITS-1:0] key;
    logic                          drain_first;
  } set_request_t;

  typedef struct packed {
    logic                            present;
    logic                            changed;
    logic                            full_res;
    logic [hslp_pkg::COUNT_BITS-1:0] count;
  } set_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      in_kind = hslp_pkg::KIND_QUERY;
  logic [hslp_pkg::KEY_BITS-1:0]   in_key = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_present;
  logic                            out_changed;
  logic                            out_full_res;
  logic [hslp_pkg::COUNT_BITS-1:0] out_count;

  set_request_t request_queue [$];
  set_result_t  expected_results [$];

  // mirror of the table contents
  hslp_pkg::slot_status_t          mirror_status [hslp_pkg::SLOTS];
  logic [hslp_pkg::KEY_BITS-1:0]   mirror_key [hslp_pkg::SLOTS];
  logic [hslp_pkg::COUNT_BITS-1:0] mirror_count = '0;

  int items_sent = 0;
  int results_seen = 0;
  int err_count = 0;
  int cycle_count = 0;
  int kind_seen [4];
  int refused_inserts = 0;
  int key_hits = 0;
  int peak_count = 0;

  hash_set_linear_probe_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_present  (out_present),
    .out_changed  (out_changed),
    .out_full_res (out_full_res),
    .out_count    (out_count)
  );

  always #1 clk = ~clk;

  // Start slot: top SLOT_BITS bits of the 64-bit Fibonacci product
  function automatic int hash_start_slot(input logic [hslp_pkg::KEY_BITS-1:0] key);
    logic [63:0] prod;
    prod = {{(64-hslp_pkg::KEY_BITS){1'b0}}, key} *
           {hslp_pkg::HASH_MUL_HI, hslp_pkg::HASH_MUL_LO};
    return int'(prod[63 -: hslp_pkg::SLOT_BITS]);
  endfunction

  // Apply one request to the mirror and queue the result it should give
  function automatic void predict_set_op(input logic [1:0] kind,
                                         input logic [hslp_pkg::KEY_BITS-1:0] key);
    set_result_t            r;
    hslp_pkg::slot_status_t st;
    int idx;
    int first_dead;
    int hit;
    int n;
    bit found;
    bit stop;
    r = '0;
    kind_seen[kind]++;
    if (kind == hslp_pkg::KIND_CLEAR) begin
      for (n = 0; n < hslp_pkg::SLOTS; n++)
        if (mirror_status[n] == hslp_pkg::ST_USED) mirror_status[n] = hslp_pkg::ST_DEAD;
      mirror_count = '0;
    end else begin
      idx = hash_start_slot(key);
      first_dead = -1;
      hit = -1;
      found = 1'b0;
      stop = 1'b0;
      // walk the probe path until a free slot, a match, or one full lap
      for (n = 0; n < hslp_pkg::SLOTS && !stop; n++) begin
        st = mirror_status[idx];
        if (st == hslp_pkg::ST_FREE) begin
          hit = (first_dead >= 0) ? first_dead : idx;
          stop = 1'b1;
        end else if (st == hslp_pkg::ST_USED && mirror_key[idx] == key) begin
          hit = idx;
          found = 1'b1;
          stop = 1'b1;
        end else begin
          if (st == hslp_pkg::ST_DEAD && first_dead < 0) first_dead = idx;
          idx = (idx + 1) % hslp_pkg::SLOTS;
        end
      end
      if (!stop) hit = first_dead;
      r.present = found;
      if (found) key_hits++;
      case (kind)
        hslp_pkg::KIND_INSERT: begin
          if (!found) begin
            if (hit >= 0) begin
              mirror_status[hit] = hslp_pkg::ST_USED;
              mirror_key[hit] = key;
              mirror_count = mirror_count + 1'b1;
              r.changed = 1'b1;
            end else begin
              r.full_res = 1'b1;
              refused_inserts++;
            end
          end
        end
        hslp_pkg::KIND_DELETE: begin
          if (found) begin
            mirror_status[hit] = hslp_pkg::ST_DEAD;
            if (mirror_count != 0) mirror_count = mirror_count - 1'b1;
            r.changed = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.count = mirror_count;
    if (int'(mirror_count) > peak_count) peak_count = int'(mirror_count);
    expected_results.push_back(r);
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Random key whose probe starts at the given slot
  function automatic logic [hslp_pkg::KEY_BITS-1:0] key_for_slot(input int slot);
    logic [hslp_pkg::KEY_BITS-1:0] k;
    k = $urandom();
    while (hash_start_slot(k) != slot) k = $urandom();
    return k;
  endfunction

  function automatic logic [hslp_pkg::KEY_BITS-1:0] fresh_key();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  task automatic push_req(input logic [1:0] kind,
                          input logic [hslp_pkg::KEY_BITS-1:0] key,
                          input logic drain_first = 1'b0);
    set_request_t req;
    req.kind = kind;
    req.key = key;
    req.drain_first = drain_first;
    request_queue.push_back(req);
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 30) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Driver: present queued requests, hold while stalled, insert random gaps
  int           drv_gap = 0;
  int           drv_calm = 0;
  set_request_t drv_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind <= hslp_pkg::KIND_QUERY;
      in_key <= '0;
      drv_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_set_op(in_kind, in_key);
        items_sent <= items_sent + 1;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (request_queue.size() != 0 &&
                   (!request_queue[0].drain_first || expected_results.size() == 0)) begin
        drv_req = request_queue.pop_front();
        in_valid <= 1'b1;
        in_kind <= drv_req.kind;
        in_key <= drv_req.key;
        if (drv_calm > 0) begin
          drv_calm--;
          drv_gap = 0;
        end else begin
          if ($urandom_range(0, 199) == 0) drv_calm = $urandom_range(40, 200);
          drv_gap = idle_len();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer, then pick the next stall value
  int          rcv_stall = 0;
  int          rcv_calm = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  set_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no pending request");
        end else begin
          want = expected_results.pop_front();
          check_field("present", int'(out_present), int'(want.present));
          check_field("changed", int'(out_changed), int'(want.changed));
          check_field("full_res", int'(out_full_res), int'(want.full_res));
          check_field("count", int'(out_count), int'(want.count));
        end
        results_seen++;
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rcv_stall > 0) begin
        rcv_stall--;
        out_stall <= 1'b1;
      end else if (rcv_calm > 0) begin
        rcv_calm--;
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) rcv_calm = $urandom_range(40, 200);
        rcv_stall = idle_len();
        if (rcv_stall > 0) begin
          rcv_stall--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_results.size());
      $display("tb_hash_set_linear_probe_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [hslp_pkg::KEY_BITS-1:0] k1, k2, k3, k4;
    logic [hslp_pkg::KEY_BITS-1:0] pool [$];
    logic [hslp_pkg::KEY_BITS-1:0] fill_keys [$];
    logic [hslp_pkg::KEY_BITS-1:0] k;
    int phase;
    int ops;
    int base;
    int i;
    int r;

    for (i = 0; i < hslp_pkg::SLOTS; i++) begin
      mirror_status[i] = hslp_pkg::ST_FREE;
      mirror_key[i] = '0;
    end
    for (i = 0; i < 4; i++) kind_seen[i] = 0;

    // directed: extremes, every kind, tombstone reuse, wrap at the table end
    k1 = key_for_slot(hslp_pkg::SLOTS - 1);
    k2 = key_for_slot(hslp_pkg::SLOTS - 1);
    k3 = key_for_slot(hslp_pkg::SLOTS - 1);
    k4 = key_for_slot(hslp_pkg::SLOTS - 1);
    push_req(hslp_pkg::KIND_QUERY, '0);
    push_req(hslp_pkg::KIND_INSERT, '0);
    push_req(hslp_pkg::KIND_INSERT, '0);
    push_req(hslp_pkg::KIND_INSERT, '1);
    push_req(hslp_pkg::KIND_QUERY, '1);
    push_req(hslp_pkg::KIND_DELETE, '0);
    push_req(hslp_pkg::KIND_DELETE, '0);
    push_req(hslp_pkg::KIND_QUERY, '0);
    push_req(hslp_pkg::KIND_INSERT, '0);
    push_req(hslp_pkg::KIND_INSERT, k1);
    push_req(hslp_pkg::KIND_INSERT, k2);
    push_req(hslp_pkg::KIND_INSERT, k3);
    push_req(hslp_pkg::KIND_DELETE, k2);
    push_req(hslp_pkg::KIND_QUERY, k3);
    push_req(hslp_pkg::KIND_INSERT, k2);
    push_req(hslp_pkg::KIND_DELETE, k1);
    push_req(hslp_pkg::KIND_INSERT, k4);
    push_req(hslp_pkg::KIND_CLEAR, '0);
    push_req(hslp_pkg::KIND_QUERY, k3);
    push_req(hslp_pkg::KIND_DELETE, k3);
    push_req(hslp_pkg::KIND_INSERT, k3);
    push_req(hslp_pkg::KIND_CLEAR, '1);
    push_req(hslp_pkg::KIND_QUERY, '1);

    // random phases
    phase = 0;
    while (request_queue.size() < ITEM_TARGET) begin
      if (phase == 2 || phase == 5) begin
        // fill to capacity, then refused inserts and tombstone reuse with no free slot
        fill_keys.delete();
        push_req(hslp_pkg::KIND_CLEAR, $urandom(), 1'b1);
        for (i = 0; i < hslp_pkg::SLOTS; i++) begin
          k = $urandom();
          fill_keys.push_back(k);
          push_req(hslp_pkg::KIND_INSERT, k);
        end
        for (i = 0; i < 4; i++) push_req(hslp_pkg::KIND_INSERT, $urandom());
        push_req(hslp_pkg::KIND_QUERY, $urandom());
        push_req(hslp_pkg::KIND_QUERY, $urandom());
        push_req(hslp_pkg::KIND_INSERT, fill_keys[$urandom_range(0, hslp_pkg::SLOTS - 1)]);
        for (i = 0; i < 3; i++)
          push_req(hslp_pkg::KIND_DELETE, fill_keys[$urandom_range(0, hslp_pkg::SLOTS - 1)]);
        for (i = 0; i < 4; i++) push_req(hslp_pkg::KIND_INSERT, $urandom());
        push_req(hslp_pkg::KIND_QUERY, fill_keys[$urandom_range(0, hslp_pkg::SLOTS - 1)]);
        push_req(hslp_pkg::KIND_DELETE, $urandom());
      end else if ($urandom_range(0, 99) < 15) begin
        // noise: any kind, any key
        ops = $urandom_range(15, 40);
        for (i = 0; i < ops; i++) push_req(2'($urandom_range(0, 3)), fresh_key());
      end else begin
        // churn over a small pool, sometimes crowded onto a few neighboring slots
        pool.delete();
        ops = $urandom_range(6, 30);
        if ($urandom_range(0, 1) == 0) begin
          base = ($urandom_range(0, 3) == 0) ? hslp_pkg::SLOTS - 2
                                             : $urandom_range(0, hslp_pkg::SLOTS - 1);
          for (i = 0; i < ops; i++)
            pool.push_back(key_for_slot((base + $urandom_range(0, 2)) % hslp_pkg::SLOTS));
        end else begin
          for (i = 0; i < ops; i++) pool.push_back(fresh_key());
        end
        ops = $urandom_range(40, 120);
        for (i = 0; i < ops; i++) begin
          k = ($urandom_range(0, 9) == 0) ? fresh_key() : pool[$urandom_range(0, pool.size() - 1)];
          r = $urandom_range(0, 99);
          if (r < 40) push_req(hslp_pkg::KIND_INSERT, k);
          else if (r < 65) push_req(hslp_pkg::KIND_QUERY, k);
          else if (r < 97) push_req(hslp_pkg::KIND_DELETE, k);
          else push_req(hslp_pkg::KIND_CLEAR, k);
        end
      end
      phase++;
    end

    // reset
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all requests out, all results back, then let the block settle
    @(posedge clk);
    while (request_queue.size() != 0 || in_valid !== 1'b0) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d insert, %0d query, %0d delete, %0d clear",
             items_sent, kind_seen[hslp_pkg::KIND_INSERT], kind_seen[hslp_pkg::KIND_QUERY],
             kind_seen[hslp_pkg::KIND_DELETE], kind_seen[hslp_pkg::KIND_CLEAR]);
    $display("key hits %0d, refused inserts %0d, peak count %0d, mismatches %0d",
             key_hits, refused_inserts, peak_count, err_count);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("tb_hash_set_linear_probe_top: PASS");
    end else begin
      $display("tb_hash_set_linear_probe_top: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/hslp_pkg.sv
rtl/hslp_ram.sv
rtl/hslp_hash.sv
rtl/hash_set_linear_probe_top.sv
verif/tb_hash_set_linear_probe_top.sv
